@@ hw/rtl/sbpw_pkg.sv @@
// shared constants, types and helpers for the semaphore bank
`default_nettype none
package sbpw_pkg;

  localparam int NUM_SEM     = 10;
  localparam int QUEUE_DEPTH = 8;

  localparam int SEM_IDX_W = (NUM_SEM > 1) ? $clog2(NUM_SEM) : 1;
  localparam int FILL_W    = $clog2(QUEUE_DEPTH + 1);
  localparam int ADDR_W    = (NUM_SEM * QUEUE_DEPTH > 1) ? $clog2(NUM_SEM * QUEUE_DEPTH) : 1;

  localparam logic [14:0]        COUNT_MAX       = 15'h7fff;
  localparam logic signed [15:0] PLAIN_USER_PRIO = 16'sd100;

  typedef enum logic [2:0] {
    ACT_INIT    = 3'd0,
    ACT_DOWN    = 3'd1,
    ACT_DOWN_UP = 3'd2,
    ACT_UP      = 3'd3,
    ACT_RELEASE = 3'd4
  } action_t;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_BAD_ID   = 3'd1;
  localparam logic [2:0] ST_INACTIVE = 3'd2;
  localparam logic [2:0] ST_ACTIVE   = 3'd3;
  localparam logic [2:0] ST_NEG      = 3'd4;
  localparam logic [2:0] ST_WAITERS  = 3'd5;
  localparam logic [2:0] ST_FULL     = 3'd6;

  localparam logic [1:0] MODE_FIFO = 2'd0;
  localparam logic [1:0] MODE_OS   = 2'd1;
  localparam logic [1:0] MODE_USER = 2'd2;

  typedef struct packed {
    logic signed [15:0] user_prio;
    logic [7:0]         os_prio;
    logic [15:0]        req_id;
  } waiter_t;

  // wake priority of a waiter under the given mode
  function automatic logic signed [16:0] wake_key(input waiter_t w, input logic [1:0] mode);
    if (mode == MODE_OS) return $signed({9'b0, w.os_prio});
    return $signed({w.user_prio[15], w.user_prio});
  endfunction

  function automatic logic [ADDR_W-1:0] slot_addr(input logic [SEM_IDX_W-1:0] sem,
                                                  input logic [FILL_W-1:0] slot);
    return ADDR_W'(int'(sem) * QUEUE_DEPTH + int'(slot));
  endfunction

endpackage
`default_nettype wire

@@ hw/rtl/sbpw_cell.sv @@
// one waiter cell of the queue shift chain
`default_nettype none
module sbpw_cell
  import sbpw_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    shift,
  input  wire waiter_t from_next,
  output waiter_t      entry
);

  waiter_t entry_r;

  always_ff @(posedge clk) begin
    if (shift) begin
      entry_r <= from_next;
    end
  end

  assign entry = entry_r;

endmodule
`default_nettype wire

@@ hw/rtl/semaphore_bank_priority_wake_top.sv @@
// top level of the semaphore bank with priority wake queues
`default_nettype none
// Bank of NUM_SEM counting semaphores, each with a wait queue of QUEUE_DEPTH
// entries held in one waiter memory. Init, down, release and an up on an empty
// queue finish in the cycle the word is accepted, so the result appears in the
// next cycle. An up with waiters streams the semaphore's queue out of the
// memory through a row of QUEUE_DEPTH cells (one read a cycle, tracking the best
// waiter as it passes), then shifts the row back to write the queue compacted.
// One word is worked on at a time; a new word is taken only while the output
// register is empty or its result is being read.
module semaphore_bank_priority_wake_top
  import sbpw_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // action[2:0] sema_id[6:3] value[22:7] wake_mode[24:23]
  // requester_id[40:25] os_priority[48:41], zero pad
  input  wire logic [55:0] in_tdata,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // status[2:0] blocked[3] woken_valid[4] woken_id[20:5], zero pad
  output logic [23:0]      out_tdata
);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_LOAD  = 3'b010,
    S_SHIFT = 3'b100
  } state_t;

  state_t state_r;

  // input word fields
  logic [2:0]         f_action;
  logic [3:0]         f_id;
  logic signed [15:0] f_value;
  logic [1:0]         f_mode;
  logic [15:0]        f_req;
  logic [7:0]         f_osp;

  assign f_action = in_tdata[2:0];
  assign f_id     = in_tdata[6:3];
  assign f_value  = $signed(in_tdata[22:7]);
  assign f_mode   = in_tdata[24:23];
  assign f_req    = in_tdata[40:25];
  assign f_osp    = in_tdata[48:41];

  // per-semaphore state
  logic [14:0]       count_r  [NUM_SEM];
  logic              active_r [NUM_SEM];
  logic [1:0]        mode_r   [NUM_SEM];
  logic [FILL_W-1:0] fill_r   [NUM_SEM];

  // waiter memory
  waiter_t waiter_mem [NUM_SEM*QUEUE_DEPTH];
  waiter_t rd_data_r;

  // up sequencing
  logic [SEM_IDX_W-1:0] cur_r;
  logic [1:0]           cur_mode_r;
  logic [FILL_W-1:0]    n_r;
  logic [FILL_W-1:0]    cnt_r;
  logic [FILL_W-1:0]    pick_r;
  logic signed [16:0]   best_r;
  logic [15:0]          best_id_r;

  // output register
  logic        out_tvalid_r;
  logic [23:0] out_tdata_r;

  logic in_fire;
  assign in_tready = (state_r == S_IDLE) && (!out_tvalid_r || out_tready);
  assign in_fire   = in_tvalid && in_tready;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  logic [SEM_IDX_W-1:0] si;
  logic                 id_ok;
  assign si    = SEM_IDX_W'(f_id);
  assign id_ok = (int'(f_id) < NUM_SEM);

  // cell row: cell k loads from cell k+1, the last cell from the memory read
  waiter_t link [QUEUE_DEPTH+1];
  logic    chain_shift;
  assign link[QUEUE_DEPTH] = rd_data_r;
  assign chain_shift = ((state_r == S_LOAD) && (cnt_r != '0)) || (state_r == S_SHIFT);

  for (genvar k = 0; k < QUEUE_DEPTH; k++) begin : g_cell
    sbpw_cell u_cell (
      .clk       (clk),
      .shift     (chain_shift),
      .from_next (link[k+1]),
      .entry     (link[k])
    );
  end

  // direct decode for the accepted word
  logic [2:0]        d_status;
  logic              d_blocked;
  logic              d_enq;
  logic              d_start_up;
  logic signed [15:0] d_uprio;

  always_comb begin
    d_status   = ST_OK;
    d_blocked  = 1'b0;
    d_enq      = 1'b0;
    d_start_up = 1'b0;
    d_uprio    = '0;
    if (f_action <= ACT_RELEASE) begin
      if (!id_ok) begin
        d_status = ST_BAD_ID;
      end else if (f_action == ACT_INIT) begin
        if (active_r[si]) d_status = ST_ACTIVE;
        else if (f_value < 0) d_status = ST_NEG;
      end else if (!active_r[si]) begin
        d_status = ST_INACTIVE;
      end else begin
        case (f_action)
          ACT_DOWN, ACT_DOWN_UP: begin
            if (f_action == ACT_DOWN_UP) d_uprio = f_value;
            else if (mode_r[si] == MODE_USER) d_uprio = PLAIN_USER_PRIO;
            if (count_r[si] == '0) begin
              if (int'(fill_r[si]) >= QUEUE_DEPTH) begin
                d_status = ST_FULL;
              end else begin
                d_enq     = 1'b1;
                d_blocked = 1'b1;
              end
            end
          end
          ACT_UP: begin
            if (fill_r[si] != '0) d_start_up = 1'b1;
          end
          ACT_RELEASE: begin
            if (fill_r[si] != '0) d_status = ST_WAITERS;
          end
          default: begin
          end
        endcase
      end
    end
  end

  // result word loads: a direct word from idle, or the end of an up sequence
  logic out_load;
  assign out_load = ((state_r == S_IDLE) && in_fire && !d_start_up)
                    || ((state_r == S_SHIFT) && (int'(cnt_r) == QUEUE_DEPTH - 1));

  // memory ports
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  waiter_t           wr_data;
  logic [FILL_W-1:0] load_idx;
  logic              shift_wr;

  assign load_idx = cnt_r - FILL_W'(1);
  assign shift_wr = (state_r == S_SHIFT) && (cnt_r >= pick_r)
                    && ((cnt_r + FILL_W'(1)) < n_r);

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = slot_addr(si, fill_r[si]);
    wr_data = '{user_prio: d_uprio, os_prio: f_osp, req_id: f_req};
    if (in_fire && d_enq) begin
      wr_en = 1'b1;
    end else if (shift_wr) begin
      wr_en   = 1'b1;
      wr_addr = slot_addr(cur_r, cnt_r);
      wr_data = link[1];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) waiter_mem[wr_addr] <= wr_data;
    if ((state_r == S_LOAD) && (int'(cnt_r) < QUEUE_DEPTH)) begin
      rd_data_r <= waiter_mem[slot_addr(cur_r, cnt_r)];
    end
  end

  // payload registers of the up sequence
  logic signed [16:0] in_key;
  assign in_key = wake_key(rd_data_r, cur_mode_r);

  always_ff @(posedge clk) begin
    if (in_fire) begin
      cur_r      <= si;
      cur_mode_r <= id_ok ? mode_r[si] : MODE_FIFO;
      n_r        <= id_ok ? fill_r[si] : '0;
      pick_r     <= '0;
      best_r     <= '0;
    end else if ((state_r == S_LOAD) && (cnt_r != '0)) begin
      if ((load_idx < n_r) && ((cur_mode_r == MODE_OS) || (cur_mode_r == MODE_USER))
          && (in_key > best_r)) begin
        best_r    <= in_key;
        pick_r    <= load_idx;
        best_id_r <= rd_data_r.req_id;
      end else if (load_idx == '0) begin
        best_id_r <= rd_data_r.req_id;
      end
    end
  end

  // control and semaphore state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      cnt_r        <= '0;
      out_tvalid_r <= 1'b0;
      out_tdata_r  <= '0;
      for (int s = 0; s < NUM_SEM; s++) begin
        count_r[s]  <= '0;
        active_r[s] <= 1'b0;
        mode_r[s]   <= MODE_FIFO;
        fill_r[s]   <= '0;
      end
    end else begin
      if (out_load) out_tvalid_r <= 1'b1;
      else if (out_tvalid_r && out_tready) out_tvalid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            if (d_start_up) begin
              state_r <= S_LOAD;
              cnt_r   <= '0;
            end else begin
              out_tdata_r  <= {3'b0, 16'b0, 1'b0, d_blocked, d_status};
              if (id_ok && (d_status == ST_OK)) begin
                case (f_action)
                  ACT_INIT: begin
                    count_r[si]  <= f_value[14:0];
                    mode_r[si]   <= f_mode;
                    active_r[si] <= 1'b1;
                    fill_r[si]   <= '0;
                  end
                  ACT_DOWN, ACT_DOWN_UP: begin
                    if (d_enq) fill_r[si] <= fill_r[si] + FILL_W'(1);
                    else count_r[si] <= count_r[si] - 15'd1;
                  end
                  ACT_UP: begin
                    if (count_r[si] != COUNT_MAX) count_r[si] <= count_r[si] + 15'd1;
                  end
                  ACT_RELEASE: begin
                    active_r[si] <= 1'b0;
                  end
                  default: begin
                  end
                endcase
              end
            end
          end
        end
        S_LOAD: begin
          // reads issue for slots 0..depth-1, data lands in the following cycle
          if (int'(cnt_r) == QUEUE_DEPTH) begin
            state_r <= S_SHIFT;
            cnt_r   <= '0;
          end else begin
            cnt_r <= cnt_r + FILL_W'(1);
          end
        end
        S_SHIFT: begin
          // write back the entries behind the woken waiter one slot earlier
          if (int'(cnt_r) == QUEUE_DEPTH - 1) begin
            state_r       <= S_IDLE;
            fill_r[cur_r] <= n_r - FILL_W'(1);
            out_tdata_r   <= {3'b0, best_id_r, 1'b1, 1'b0, ST_OK};
          end else begin
            cnt_r <= cnt_r + FILL_W'(1);
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire
